// ===== hw/rtl/srt_pkg.sv =====
// Shared types and constants for the shortest-remaining-time scheduler.
`timescale 1ns / 1ps

package srt_pkg;

  // Fixed field widths of the request and response words.
  localparam int OP_W   = 2;
  localparam int SLOT_W = 3;
  localparam int FLD_W  = 16;
  localparam int SUM_W  = 32;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SUM,
    ST_FINISH
  } state_t;

  // Commands broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic load;
    logic clear;
    logic dec;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/srt_req_if.sv =====
// Request channel carrying one scheduler command word.
`timescale 1ns / 1ps

interface srt_req_if
  import srt_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [SLOT_W-1:0] slot;
  logic [FLD_W-1:0] arrival_time;
  logic [FLD_W-1:0] burst_length;

  modport source (output valid, output op, output slot, output arrival_time,
                  output burst_length, input ready);
  modport sink   (input valid, input op, input slot, input arrival_time,
                  input burst_length, output ready);
endinterface

// ===== hw/rtl/srt_rsp_if.sv =====
// Response channel carrying one scheduler status word.
`timescale 1ns / 1ps

interface srt_rsp_if
  import srt_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [FLD_W-1:0]        tick_time;
  logic [SLOT_W-1:0]       running_slot;
  logic                    idle;
  logic                    job_finished;
  logic                    all_done;
  logic signed [SUM_W-1:0] waiting_sum;
  logic [SUM_W-1:0]        turnaround_sum;

  modport source (output valid, output tick_time, output running_slot, output idle,
                  output job_finished, output all_done, output waiting_sum,
                  output turnaround_sum, input ready);
  modport sink   (input valid, input tick_time, input running_slot, input idle,
                  input job_finished, input all_done, input waiting_sum,
                  input turnaround_sum, output ready);
endinterface

// ===== hw/rtl/srt_cell.sv =====
// One job slot of the scheduler chain, with its stage of the selection wave.
`timescale 1ns / 1ps

module srt_cell
  import srt_pkg::*;
#(
  parameter int NUM_SLOTS  = 8,
  parameter int TIME_WIDTH = 16,
  parameter int CELL_IDX   = 0,
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctl_t             ctl,
  input  logic [IDX_W-1:0]      sel_idx,
  input  logic [TIME_WIDTH-1:0] ld_arrival,
  input  logic [TIME_WIDTH-1:0] ld_burst,
  input  logic [TIME_WIDTH-1:0] now,
  input  logic                  in_go,
  input  logic                  in_found,
  input  logic [TIME_WIDTH-1:0] in_rem,
  input  logic [IDX_W-1:0]      in_idx,
  input  logic [TIME_WIDTH-1:0] in_arr,
  input  logic [TIME_WIDTH-1:0] in_burst,
  output logic                  out_go,
  output logic                  out_found,
  output logic [TIME_WIDTH-1:0] out_rem,
  output logic [IDX_W-1:0]      out_idx,
  output logic [TIME_WIDTH-1:0] out_arr,
  output logic [TIME_WIDTH-1:0] out_burst,
  output logic                  is_valid,
  output logic                  is_done
);

  logic [TIME_WIDTH-1:0] arrival;
  logic [TIME_WIDTH-1:0] burst;
  logic [TIME_WIDTH-1:0] remaining;
  logic                  valid;
  logic                  sel;
  logic                  cand;
  logic                  take;

  assign sel      = (sel_idx == IDX_W'(CELL_IDX));
  assign cand     = valid && (arrival <= now) && (remaining != '0);
  // Strict compare keeps the earlier (lower) slot on a tie.
  assign take     = cand && (!in_found || (remaining < in_rem));
  assign is_valid = valid;
  assign is_done  = (remaining == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= 1'b0;
      remaining <= '0;
      out_go    <= 1'b0;
    end else begin
      out_go <= in_go;
      if (ctl.clear) begin
        valid     <= 1'b0;
        remaining <= '0;
      end else if (ctl.load && sel) begin
        valid     <= 1'b1;
        remaining <= ld_burst;
      end else if (ctl.dec && sel) begin
        remaining <= remaining - TIME_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && sel) begin
      arrival <= ld_arrival;
      burst   <= ld_burst;
    end
    if (in_go) begin
      out_found <= in_found || cand;
      if (take) begin
        out_rem   <= remaining;
        out_idx   <= IDX_W'(CELL_IDX);
        out_arr   <= arrival;
        out_burst <= burst;
      end else begin
        out_rem   <= in_rem;
        out_idx   <= in_idx;
        out_arr   <= in_arr;
        out_burst <= in_burst;
      end
    end
  end

endmodule

// ===== hw/rtl/shortest_remaining_time_scheduler.sv =====
// Top level of the preemptive shortest-remaining-time scheduler.
`timescale 1ns / 1ps

// The scheduler keeps NUM_SLOTS job slots in a chain of cells and answers every
// request word with exactly one status word. A load word (op 0) fills a slot
// with an arrival time and a burst length; a clear word (op 2) empties the table
// and zeroes the time and the sums; op 3 only reports status. A tick word (op 1)
// runs one unit of work: a selection wave starts at slot 0 and moves one cell
// per clock, each cell keeping the best candidate so far (arrived, work left,
// least remaining time, lowest slot on a tie). When the wave leaves the last
// cell the winner is decremented, and on completion the waiting sum grows by
// finish - arrival - burst - 1 and the turnaround sum by finish - arrival, with
// finish one past the tick time. A tick goes from acceptance to the status word
// through the wave in the chain, the winner update, the sum update and the
// response register; load, clear and op 3 go straight to the response register.
// One word is in work at a time, and a new word is accepted as soon
// as the previous response is in the output register, even if it has not yet
// been taken. Slot validity and remaining time clear at reset; arrival and
// burst storage is not reset and is only read for loaded slots. The time
// counter saturates at its maximum value. Loads to slots at or beyond
// NUM_SLOTS are ignored, and a burst of zero is taken as one.
module shortest_remaining_time_scheduler
  import srt_pkg::*;
#(
  parameter int NUM_SLOTS  = 8,
  parameter int TIME_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  srt_req_if.sink   req,
  srt_rsp_if.source rsp
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  state_t state, state_next;

  // Scheduler state.
  logic [TIME_WIDTH-1:0] cur_time;
  logic [CNT_W-1:0]      finished_count;
  logic [CNT_W-1:0]      loaded_count;
  logic [SUM_W-1:0]      wait_total;
  logic [SUM_W-1:0]      turnaround_total;

  // Response fields of the word in work, and the sum increments of a finish.
  logic [TIME_WIDTH-1:0] res_time;
  logic [SLOT_W-1:0]     res_ran;
  logic                  res_idle;
  logic                  res_fin;
  logic [SUM_W-1:0]      wait_delta;
  logic [SUM_W-1:0]      turn_delta;

  // Output register.
  logic                  out_valid;
  logic [FLD_W-1:0]      out_time;
  logic [SLOT_W-1:0]     out_ran;
  logic                  out_idle;
  logic                  out_fin;
  logic                  out_all;
  logic [SUM_W-1:0]      out_wait;
  logic [SUM_W-1:0]      out_turn;

  // Selection wave through the chain; element 0 is the wave's entry.
  logic                  tk_go    [NUM_SLOTS+1];
  logic                  tk_found [NUM_SLOTS+1];
  logic [TIME_WIDTH-1:0] tk_rem   [NUM_SLOTS+1];
  logic [IDX_W-1:0]      tk_idx   [NUM_SLOTS+1];
  logic [TIME_WIDTH-1:0] tk_arr   [NUM_SLOTS+1];
  logic [TIME_WIDTH-1:0] tk_burst [NUM_SLOTS+1];

  logic [NUM_SLOTS-1:0]  slot_valid;
  logic [NUM_SLOTS-1:0]  slot_done;

  cell_ctl_t             ctl;
  logic [IDX_W-1:0]      sel_idx;
  logic [IDX_W-1:0]      req_idx;
  logic [TIME_WIDTH-1:0] ld_arrival;
  logic [TIME_WIDTH-1:0] ld_burst;
  logic [TIME_WIDTH-1:0] ld_burst_raw;
  logic                  accept;
  logic                  in_range;
  logic                  apply;
  logic                  win_found;
  logic                  win_last;
  logic                  rsp_free;
  op_t                   req_op;

  assign req_op       = op_t'(req.op);
  assign req.ready    = (state == ST_IDLE);
  assign accept       = req.valid && req.ready;
  assign in_range     = (32'(req.slot) < NUM_SLOTS);
  assign req_idx      = IDX_W'(req.slot);
  assign ld_arrival   = TIME_WIDTH'(req.arrival_time);
  assign ld_burst_raw = TIME_WIDTH'(req.burst_length);
  assign ld_burst     = (ld_burst_raw == '0) ? TIME_WIDTH'(1) : ld_burst_raw;

  // The wave has left the last cell: its token holds the winner.
  assign apply     = (state == ST_SCAN) && tk_go[NUM_SLOTS];
  assign win_found = tk_found[NUM_SLOTS];
  assign win_last  = (tk_rem[NUM_SLOTS] == TIME_WIDTH'(1));
  assign rsp_free  = !out_valid || rsp.ready;

  assign ctl.load  = accept && (req_op == OP_LOAD) && in_range;
  assign ctl.clear = accept && (req_op == OP_CLEAR);
  assign ctl.dec   = apply && win_found;
  assign sel_idx   = (state == ST_IDLE) ? req_idx : tk_idx[NUM_SLOTS];

  assign tk_go[0]    = accept && (req_op == OP_TICK);
  assign tk_found[0] = 1'b0;
  assign tk_rem[0]   = '0;
  assign tk_idx[0]   = '0;
  assign tk_arr[0]   = '0;
  assign tk_burst[0] = '0;

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    srt_cell #(
      .NUM_SLOTS  (NUM_SLOTS),
      .TIME_WIDTH (TIME_WIDTH),
      .CELL_IDX   (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .sel_idx    (sel_idx),
      .ld_arrival (ld_arrival),
      .ld_burst   (ld_burst),
      .now        (cur_time),
      .in_go      (tk_go[i]),
      .in_found   (tk_found[i]),
      .in_rem     (tk_rem[i]),
      .in_idx     (tk_idx[i]),
      .in_arr     (tk_arr[i]),
      .in_burst   (tk_burst[i]),
      .out_go     (tk_go[i+1]),
      .out_found  (tk_found[i+1]),
      .out_rem    (tk_rem[i+1]),
      .out_idx    (tk_idx[i+1]),
      .out_arr    (tk_arr[i+1]),
      .out_burst  (tk_burst[i+1]),
      .is_valid   (slot_valid[i]),
      .is_done    (slot_done[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (req_op == OP_TICK) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (apply) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Time, counts and sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time         <= '0;
      finished_count   <= '0;
      loaded_count     <= '0;
      wait_total       <= '0;
      turnaround_total <= '0;
    end else begin
      if (ctl.clear) begin
        cur_time         <= '0;
        finished_count   <= '0;
        loaded_count     <= '0;
        wait_total       <= '0;
        turnaround_total <= '0;
      end else if (ctl.load) begin
        // Reloading a finished slot takes its completion back.
        if (slot_valid[req_idx]) begin
          if (slot_done[req_idx] && (finished_count != '0)) begin
            finished_count <= finished_count - CNT_W'(1);
          end
        end else begin
          loaded_count <= loaded_count + CNT_W'(1);
        end
      end
      if (apply) begin
        if (cur_time != '1) begin
          cur_time <= cur_time + TIME_WIDTH'(1);
        end
        if (win_found && win_last) begin
          finished_count <= finished_count + CNT_W'(1);
        end
      end
      if ((state == ST_SUM) && res_fin) begin
        wait_total       <= wait_total + wait_delta;
        turnaround_total <= turnaround_total + turn_delta;
      end
    end
  end

  // Response fields of the word in work.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_time <= (req_op == OP_CLEAR) ? '0 : cur_time;
      res_ran  <= '0;
      res_idle <= 1'b1;
      res_fin  <= 1'b0;
    end
    if (apply) begin
      res_ran  <= win_found ? SLOT_W'(tk_idx[NUM_SLOTS]) : '0;
      res_idle <= !win_found;
      res_fin  <= win_found && win_last;
      // With finish = time + 1, the wait increment is time - arrival - burst.
      wait_delta <= SUM_W'(cur_time) - SUM_W'(tk_arr[NUM_SLOTS])
                    - SUM_W'(tk_burst[NUM_SLOTS]);
      turn_delta <= SUM_W'(cur_time) + SUM_W'(1) - SUM_W'(tk_arr[NUM_SLOTS]);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_FINISH) && rsp_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && rsp_free) begin
      out_time <= FLD_W'(res_time);
      out_ran  <= res_ran;
      out_idle <= res_idle;
      out_fin  <= res_fin;
      out_all  <= (finished_count == loaded_count);
      out_wait <= wait_total;
      out_turn <= turnaround_total;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.tick_time      = out_time;
  assign rsp.running_slot   = out_ran;
  assign rsp.idle           = out_idle;
  assign rsp.job_finished   = out_fin;
  assign rsp.all_done       = out_all;
  assign rsp.waiting_sum    = $signed(out_wait);
  assign rsp.turnaround_sum = out_turn;

endmodule

// ===== tb/tb_shortest_remaining_time_scheduler.sv =====
// Self-checking testbench for the shortest-remaining-time scheduler.
`timescale 1ns / 1ps

module tb_shortest_remaining_time_scheduler;
  import srt_pkg::*;

  localparam int SLOTS = 8;
  localparam int TW    = 16;
  localparam logic [FLD_W-1:0] TIME_TOP = '1;

  // One request word as the sender sees it.
  typedef struct packed {
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [FLD_W-1:0]  arrival;
    logic [FLD_W-1:0]  burst;
  } req_word_t;

  // One status word as the scheduler should report it.
  typedef struct packed {
    logic [FLD_W-1:0]        tick_time;
    logic [SLOT_W-1:0]       running_slot;
    logic                    idle;
    logic                    job_finished;
    logic                    all_done;
    logic signed [SUM_W-1:0] waiting_sum;
    logic [SUM_W-1:0]        turnaround_sum;
  } status_word_t;

  logic clk = 1'b0;
  logic rst;

  srt_req_if req_bus ();
  srt_rsp_if rsp_bus ();

  shortest_remaining_time_scheduler #(
    .NUM_SLOTS (SLOTS),
    .TIME_WIDTH(TW)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_bus),
    .rsp(rsp_bus)
  );

  always #4 clk = ~clk;

  // Words waiting to be sent, and the status words that accepted words must produce.
  req_word_t    word_pending[$];
  status_word_t status_expected[$];
  req_word_t    word_on_bus;

  // When set, neither side inserts gaps; used for the back-to-back stretch.
  bit steady;
  int mismatches;

  // Job table and counters of the scheduler as the testbench tracks them.
  logic [FLD_W-1:0]        tbl_arrival [SLOTS];
  logic [FLD_W-1:0]        tbl_burst   [SLOTS];
  logic [FLD_W-1:0]        tbl_left    [SLOTS];
  logic                    tbl_used    [SLOTS];
  logic [FLD_W-1:0]        now_time;
  logic [3:0]              done_cnt;
  logic [3:0]              used_cnt;
  logic signed [SUM_W-1:0] wait_acc;
  logic [SUM_W-1:0]        turn_acc;

  function automatic void table_clear();
    int i;
    for (i = 0; i < SLOTS; i++) begin
      tbl_arrival[i] = '0;
      tbl_burst[i]   = '0;
      tbl_left[i]    = '0;
      tbl_used[i]    = 1'b0;
    end
    now_time = '0;
    done_cnt = '0;
    used_cnt = '0;
    wait_acc = '0;
    turn_acc = '0;
  endfunction

  // Applies one accepted word to the tracked table and returns its status word.
  function automatic status_word_t srtf_step(req_word_t w);
    status_word_t     s;
    logic [FLD_W-1:0] b;
    logic [FLD_W-1:0] t;
    logic [SUM_W-1:0] fin;
    int               best;
    int               i;
    s      = '0;
    s.idle = 1'b1;
    t      = now_time;
    case (w.op)
      OP_LOAD: begin
        // A zero burst is taken as one tick of work.
        b = (w.burst == '0) ? FLD_W'(1) : w.burst;
        if (tbl_used[w.slot]) begin
          // Reloading a finished job takes it off the finished count.
          if (tbl_left[w.slot] == '0 && done_cnt != '0) done_cnt = done_cnt - 4'd1;
        end else begin
          tbl_used[w.slot] = 1'b1;
          used_cnt         = used_cnt + 4'd1;
        end
        tbl_arrival[w.slot] = w.arrival;
        tbl_burst[w.slot]   = b;
        tbl_left[w.slot]    = b;
      end
      OP_TICK: begin
        best = -1;
        for (i = 0; i < SLOTS; i++) begin
          if (tbl_used[i] && tbl_arrival[i] <= t && tbl_left[i] != '0) begin
            // Strict less-than keeps the lowest slot on a tie.
            if (best < 0 || tbl_left[i] < tbl_left[best]) best = i;
          end
        end
        if (best >= 0) begin
          s.idle         = 1'b0;
          s.running_slot = SLOT_W'(best);
          tbl_left[best] = tbl_left[best] - FLD_W'(1);
          if (tbl_left[best] == '0) begin
            // Finish is one past the tick time, even with the clock saturated.
            fin            = SUM_W'(t) + SUM_W'(1);
            s.job_finished = 1'b1;
            done_cnt       = done_cnt + 4'd1;
            wait_acc = wait_acc + (fin - SUM_W'(tbl_arrival[best]) -
                                   SUM_W'(tbl_burst[best]) - SUM_W'(1));
            turn_acc = turn_acc + (fin - SUM_W'(tbl_arrival[best]));
          end
        end
        if (now_time != TIME_TOP) now_time = now_time + FLD_W'(1);
      end
      OP_CLEAR: begin
        table_clear();
        t = now_time;
      end
      default: begin
        // A status-only word leaves everything as it is.
      end
    endcase
    s.tick_time      = t;
    s.all_done       = (done_cnt == used_cnt);
    s.waiting_sum    = wait_acc;
    s.turnaround_sum = turn_acc;
    return s;
  endfunction

  // Sender: keeps a word on the bus until it is taken, then may leave a gap.
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        status_expected.push_back(srtf_step(word_on_bus));
      end
      if (!req_bus.valid || req_bus.ready) begin
        if (word_pending.size() != 0 && (steady || $urandom_range(99) >= 30)) begin
          word_on_bus = word_pending.pop_front();
          req_bus.valid        <= 1'b1;
          req_bus.op           <= word_on_bus.op;
          req_bus.slot         <= word_on_bus.slot;
          req_bus.arrival_time <= word_on_bus.arrival;
          req_bus.burst_length <= word_on_bus.burst;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks every status word taken against the oldest expectation.
  always @(posedge clk) begin : status_check
    status_word_t got;
    status_word_t want;
    if (rst) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        got.tick_time      = rsp_bus.tick_time;
        got.running_slot   = rsp_bus.running_slot;
        got.idle           = rsp_bus.idle;
        got.job_finished   = rsp_bus.job_finished;
        got.all_done       = rsp_bus.all_done;
        got.waiting_sum    = rsp_bus.waiting_sum;
        got.turnaround_sum = rsp_bus.turnaround_sum;
        if (status_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: status word with nothing expected: time %0d slot %0d idle %0b",
                     $realtime, got.tick_time, got.running_slot, got.idle);
          end
        end else begin
          want = status_expected.pop_front();
          if (got.tick_time !== want.tick_time || got.running_slot !== want.running_slot ||
              got.idle !== want.idle || got.job_finished !== want.job_finished ||
              got.all_done !== want.all_done || got.waiting_sum !== want.waiting_sum ||
              got.turnaround_sum !== want.turnaround_sum) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp time %0d slot %0d idle %0b fin %0b done %0b",
                       $realtime, want.tick_time, want.running_slot, want.idle,
                       want.job_finished, want.all_done);
              $display("          exp wait %0d turn %0d", want.waiting_sum,
                       want.turnaround_sum);
              $display("          got time %0d slot %0d idle %0b fin %0b done %0b",
                       got.tick_time, got.running_slot, got.idle, got.job_finished,
                       got.all_done);
              $display("          got wait %0d turn %0d", got.waiting_sum,
                       got.turnaround_sum);
            end
          end
        end
      end
      rsp_bus.ready <= steady || ($urandom_range(99) >= 30);
    end
  end

  task automatic queue_word(input op_t op, input int slot, input int arr, input int bl);
    req_word_t w;
    w.op      = op;
    w.slot    = SLOT_W'(slot);
    w.arrival = FLD_W'(arr);
    w.burst   = FLD_W'(bl);
    word_pending.push_back(w);
  endtask

  // Waits until every queued word is sent and every status word has come back.
  task automatic drain();
    while (word_pending.size() != 0 || req_bus.valid || status_expected.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int queued_random;
    int jobs;
    int work;
    int last_arr;
    int ticks;
    int arr;
    int bl;
    int pick;
    rst                  = 1'b1;
    steady               = 1'b0;
    mismatches           = 0;
    req_bus.valid        = 1'b0;
    req_bus.op           = OP_LOAD;
    req_bus.slot         = '0;
    req_bus.arrival_time = '0;
    req_bus.burst_length = '0;
    rsp_bus.ready        = 1'b0;
    table_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Fresh status and an idle tick on an empty table come first.
    queue_word(OP_NONE, 0, 0, 0);
    queue_word(OP_TICK, 0, 0, 0);
    // A zero burst, the widest arrival and burst, and two equal jobs for the tie rule.
    queue_word(OP_LOAD, 0, 0, 0);
    queue_word(OP_LOAD, 7, 16'hFFFF, 16'hFFFF);
    queue_word(OP_LOAD, 3, 2, 2);
    queue_word(OP_LOAD, 5, 2, 2);
    repeat (6) queue_word(OP_TICK, 0, 0, 0);
    // Reloading finished slots; the job arriving now finishes with a wait of minus one.
    queue_word(OP_LOAD, 0, 7, 1);
    queue_word(OP_LOAD, 3, 0, 3);
    queue_word(OP_TICK, 0, 0, 0);
    queue_word(OP_TICK, 0, 0, 0);
    queue_word(OP_CLEAR, 0, 0, 0);
    queue_word(OP_TICK, 0, 0, 0);
    // Reloading a slot whose job has not finished yet.
    queue_word(OP_LOAD, 2, 0, 1);
    queue_word(OP_LOAD, 2, 0, 5);
    queue_word(OP_TICK, 0, 0, 0);
    queue_word(OP_NONE, 7, 16'hFFFF, 16'hFFFF);
    queue_word(OP_CLEAR, 0, 0, 0);

    // Random part. Most of it is job sets that are then ticked to completion,
    // with reloads and status words mixed into the ticks; the rest is raw noise
    // over the full range of every field.
    queued_random = 0;
    while (queued_random < 480) begin
      if ($urandom_range(9) < 8) begin
        if ($urandom_range(3) != 0) begin
          queue_word(OP_CLEAR, $urandom_range(7), $urandom_range(65535), $urandom_range(65535));
          queued_random++;
        end
        jobs     = $urandom_range(1, 5);
        work     = 0;
        last_arr = 0;
        repeat (jobs) begin
          arr = $urandom_range(12);
          bl  = $urandom_range(12);
          queue_word(OP_LOAD, $urandom_range(7), arr, bl);
          queued_random++;
          work += (bl == 0) ? 1 : bl;
          if (arr > last_arr) last_arr = arr;
        end
        ticks = last_arr + work + $urandom_range(3);
        repeat (ticks) begin
          pick = $urandom_range(19);
          if (pick == 0) begin
            queue_word(OP_NONE, $urandom_range(7), $urandom_range(65535),
                       $urandom_range(65535));
          end else if (pick == 1) begin
            queue_word(OP_LOAD, $urandom_range(7), $urandom_range(12), $urandom_range(1, 12));
          end else begin
            queue_word(OP_TICK, $urandom_range(7), $urandom_range(65535),
                       $urandom_range(65535));
          end
          queued_random++;
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          queue_word(op_t'($urandom_range(3)), $urandom_range(7), $urandom_range(65535),
                     $urandom_range(65535));
          queued_random++;
        end
      end
    end
    drain();

    // Back-to-back stretch with no gaps on either side. A long job is preempted
    // by a shorter arrival, a third job arrives later, and idle ticks follow.
    steady = 1'b1;
    queue_word(OP_CLEAR, 0, 0, 0);
    queue_word(OP_LOAD, 0, 0, 20);
    queue_word(OP_LOAD, 2, 4, 3);
    queue_word(OP_LOAD, 1, 10, 2);
    repeat (30) queue_word(OP_TICK, 0, 0, 0);
    queue_word(OP_NONE, 0, 0, 0);
    drain();
    steady = 1'b0;

    // Let any stray status word surface before the verdict.
    repeat (40) @(negedge clk);
    if (mismatches == 0 && status_expected.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
